[hw/rtl/fiff_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fiff_pkg;

  localparam int unsigned MAX_INTERVALS = 64;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned IDX_W = $clog2(MAX_INTERVALS);
  localparam int unsigned CNT_W = IDX_W + 1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic KIND_RESERVE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [ADDR_W-1:0] POOL_RESET = ADDR_W'(65536);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_EVAL,
    S_SPLIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic init;
    logic load;
    logic read;
    logic eval;
    logic wr_hi;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic init_pend;
    logic is_query;
    logic skip;
    logic walk_done;
    logic hit;
    logic split;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/fiff_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fiff_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  fiff_pkg::dp_stat_t  stat,
  output fiff_pkg::ctl_cmd_t  cmd
);
  import fiff_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (stat.init_pend) begin
          cmd.init = 1'b1;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load = 1'b1;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (stat.skip) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (stat.walk_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.read = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.is_query && stat.hit) begin
          state_nxt = S_FIN;
        end else if (!stat.is_query && stat.split) begin
          state_nxt = S_SPLIT;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_SPLIT: begin
        cmd.wr_hi = 1'b1;
        state_nxt = S_READ;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/fiff_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module fiff_dp (
  input  wire                         clk,
  input  wire                         rst_n,
  input  fiff_pkg::ctl_cmd_t          cmd,
  output fiff_pkg::dp_stat_t          stat,
  input  wire                         cfg_we,
  input  wire  [fiff_pkg::ADDR_W-1:0] cfg_wdata,
  input  wire                         in_kind,
  input  wire  [fiff_pkg::ADDR_W-1:0] in_range_start,
  input  wire  [fiff_pkg::ADDR_W-1:0] in_range_end,
  input  wire  [fiff_pkg::ADDR_W-1:0] in_request_length,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [1:0]                  out_status,
  output logic [fiff_pkg::ADDR_W-1:0] out_found_offset
);
  import fiff_pkg::*;

  logic [ADDR_W-1:0] mem_end [2*MAX_INTERVALS];
  logic [ADDR_W-1:0] mem_len [2*MAX_INTERVALS];

  logic [ADDR_W-1:0] pool_r;
  logic              init_pend_r;
  logic              bank_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  n_r;
  logic              kind_r;
  logic              skip_r;
  logic              hit_r;
  logic [ADDR_W-1:0] s_r, e_r, want_r;
  logic [ADDR_W-1:0] rd_end_r, rd_len_r;
  logic [ADDR_W-1:0] off_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_off_r;

  logic [ADDR_W-1:0] a_cur;
  logic              ovl;
  logic              full;
  logic              we;
  logic [IDX_W:0]    wa;
  logic [ADDR_W-1:0] wd_end, wd_len;

  assign a_cur = (rd_len_r <= rd_end_r) ? (rd_end_r - rd_len_r) : '0;
  assign ovl = !((rd_end_r <= s_r) || (a_cur >= e_r));
  assign full = (n_r > CNT_W'(MAX_INTERVALS));

  assign stat.init_pend = init_pend_r;
  assign stat.is_query = (kind_r == KIND_QUERY);
  assign stat.skip = skip_r;
  assign stat.walk_done = (i_r == count_r);
  assign stat.hit = (rd_len_r >= want_r);
  assign stat.split = ovl && (a_cur < s_r) && (e_r < rd_end_r);
  assign stat.out_busy = out_valid_r && !out_ready;

  always_comb begin
    we = 1'b0;
    wa = {~bank_r, n_r[IDX_W-1:0]};
    wd_end = rd_end_r;
    wd_len = rd_len_r;
    if (cmd.init) begin
      we = 1'b1;
      wa = {bank_r, IDX_W'(0)};
      wd_end = pool_r;
      wd_len = pool_r;
    end else if (cmd.wr_hi) begin
      we = !n_r[IDX_W];
      wd_len = rd_end_r - e_r;
    end else if (cmd.eval && kind_r == KIND_RESERVE) begin
      we = !n_r[IDX_W];
      if (!ovl) begin
        wd_end = rd_end_r;
      end else if (a_cur < s_r) begin
        wd_end = s_r;
        wd_len = s_r - a_cur;
      end else if (e_r < rd_end_r) begin
        wd_len = rd_end_r - e_r;
      end else begin
        we = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_end[wa] <= wd_end;
      mem_len[wa] <= wd_len;
    end
    if (cmd.read) begin
      rd_end_r <= mem_end[{bank_r, i_r[IDX_W-1:0]}];
      rd_len_r <= mem_len[{bank_r, i_r[IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      s_r <= in_range_start;
      e_r <= in_range_end;
      want_r <= in_request_length;
      skip_r <= (in_kind == KIND_RESERVE) && (in_range_start >= in_range_end);
    end
    if (cmd.emit) begin
      if (kind_r == KIND_QUERY) begin
        out_status_r <= hit_r ? ST_OK : ST_NO_FIT;
        out_off_r <= hit_r ? off_r : '0;
      end else begin
        out_status_r <= (!skip_r && full) ? ST_FULL : ST_OK;
        out_off_r <= '0;
      end
    end
    if (cmd.eval && kind_r == KIND_QUERY && stat.hit) begin
      off_r <= a_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= POOL_RESET;
      init_pend_r <= 1'b1;
      bank_r <= 1'b0;
      count_r <= CNT_W'(1);
      i_r <= '0;
      n_r <= '0;
      hit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_r <= cfg_wdata;
        init_pend_r <= 1'b1;
      end else if (cmd.init) begin
        init_pend_r <= 1'b0;
      end
      if (cmd.init) begin
        count_r <= CNT_W'(1);
      end
      if (cmd.load) begin
        i_r <= '0;
        n_r <= '0;
        hit_r <= 1'b0;
      end
      if (cmd.eval) begin
        i_r <= i_r + CNT_W'(1);
        if (kind_r == KIND_QUERY) begin
          hit_r <= stat.hit;
        end else if (!ovl || (a_cur < s_r) || (e_r < rd_end_r)) begin
          n_r <= n_r + CNT_W'(1);
        end
      end
      if (cmd.wr_hi) begin
        n_r <= n_r + CNT_W'(1);
      end
      if (cmd.emit && kind_r == KIND_RESERVE && !skip_r && !full) begin
        bank_r <= ~bank_r;
        count_r <= n_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_found_offset = out_off_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_INTERVALS)) else $error("interval count above table depth");

  a_init_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init |=> count_r == CNT_W'(1)) else $error("init did not leave one interval");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> (i_r < count_r) && (n_r <= i_r + CNT_W'(1)))
    else $error("walk index out of range");

endmodule

`default_nettype wire

[hw/rtl/free_interval_first_fit_core.sv]
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_kind, in_range_start, in_range_end,
//                     in_request_length
// out      output     out_valid, out_ready, out_status, out_found_offset
// cfg      input      cfg_we, cfg_wdata
//
// After acceptance a query reads and evaluates one interval at a time and stops at
// the first fit or after the last interval. A reserve walks every stored interval,
// with an extra write for a split; an empty or reversed range skips the walk.
// The interval memory has a single read port, so the walk reads one interval per step.
// After reset or a cfg write, the table is rebuilt before an item is taken.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

module free_interval_first_fit_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_kind,
  input  wire  [fiff_pkg::ADDR_W-1:0] in_range_start,
  input  wire  [fiff_pkg::ADDR_W-1:0] in_range_end,
  input  wire  [fiff_pkg::ADDR_W-1:0] in_request_length,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [1:0]                  out_status,
  output logic [fiff_pkg::ADDR_W-1:0] out_found_offset,
  input  wire                         cfg_we,
  input  wire  [fiff_pkg::ADDR_W-1:0] cfg_wdata
);
  import fiff_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  fiff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fiff_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_kind),
    .in_range_start    (in_range_start),
    .in_range_end      (in_range_end),
    .in_request_length (in_request_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_offset  (out_found_offset)
  );

endmodule

`default_nettype wire
